>>> hw/rtl/lruc_pkg.sv
// Shared constants for the LRU cache table.
package lruc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

endpackage

>>> hw/rtl/lruc_lookup.sv
// Parallel key match, free-slot pick and LRU victim pick over all entries.
module lruc_lookup #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF,
  parameter int RANK_W  = 4
) (
  input  logic [lruc_pkg::KEY_W-1:0] key,
  input  logic [lruc_pkg::KEY_W-1:0] entry_key [ENTRIES],
  input  logic [ENTRIES-1:0]         entry_valid,
  input  logic [RANK_W-1:0]          entry_rank [ENTRIES],
  input  logic [RANK_W-1:0]          oldest_rank,
  output logic [ENTRIES-1:0]         match_oh,
  output logic [ENTRIES-1:0]         free_oh,
  output logic [ENTRIES-1:0]         victim_oh
);
  import lruc_pkg::*;

  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] oldest_vec;
  logic [ENTRIES-1:0] free_vec;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = entry_valid[i] && (entry_key[i] == key);
      oldest_vec[i] = entry_valid[i] && (entry_rank[i] == oldest_rank);
    end
  end

  assign free_vec = ~entry_valid;

  // keep only the lowest set bit
  assign match_oh  = match_vec & (~match_vec + 1'b1);
  assign free_oh   = free_vec & (~free_vec + 1'b1);
  // ranks of valid entries are a permutation, so the oldest one is unique
  assign victim_oh = oldest_vec & (~oldest_vec + 1'b1);

endmodule

>>> hw/rtl/lru_cache_table.sv
// Top level: fully associative key-value cache with LRU replacement.
//
//  channel | dir | sideband        | payload
//  --------+-----+-----------------+---------------------------------
//  in_     | in  | tuser = cmd     | tdata = key, value
//  out_    | out | tuser = hit     | tdata = read_value
//  cfg_    | in  | wr_en           | wr_data = capacity_in_use
//
// One access is taken per cycle unless a get is held; the match/rank update
// over the whole table is one stage between the input register and the
// result register, where a get leaves its result; a put gives none.
// Reset clears control state and entry valid bits; keys, values and ranks
// are left as they are. A get waits in the input register while the result
// register is still full and not taken.
module lru_cache_table #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,   // [0] cmd
  input  logic [2*lruc_pkg::KEY_W-1:0] in_tdata,  // [31:0] key, [63:32] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic                        out_tuser,  // [0] hit
  output logic [lruc_pkg::VAL_W-1:0]  out_tdata,  // [31:0] read_value
  input  logic                        cfg_wr_en,
  input  logic [lruc_pkg::CAP_W-1:0]  cfg_wr_data
);
  import lruc_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  logic [CAP_W-1:0]  cap_r;

  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [VAL_W-1:0]  s1_val_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_val_r;

  logic [KEY_W-1:0]  entry_key_r   [ENTRIES];
  logic [VAL_W-1:0]  entry_val_r   [ENTRIES];
  logic [RANK_W-1:0] entry_rank_r  [ENTRIES];
  logic [RANK_W-1:0] entry_rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] entry_valid_r;
  logic [OCC_W-1:0]  occ_r;

  logic [ENTRIES-1:0] match_oh, free_oh, victim_oh, wr_oh;
  logic [RANK_W-1:0]  oldest_rank, hit_rank, age_limit;
  logic [VAL_W-1:0]   hit_value;
  logic [CMP_W-1:0]   eff_cap;
  logic               hit, is_put, can_fill, fill, touch, out_free, proc;

  assign oldest_rank = RANK_W'(occ_r - 1'b1);

  lruc_lookup #(
    .ENTRIES (ENTRIES),
    .RANK_W  (RANK_W)
  ) u_lookup (
    .key         (s1_key_r),
    .entry_key   (entry_key_r),
    .entry_valid (entry_valid_r),
    .entry_rank  (entry_rank_r),
    .oldest_rank (oldest_rank),
    .match_oh    (match_oh),
    .free_oh     (free_oh),
    .victim_oh   (victim_oh)
  );

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | (match_oh[i] ? entry_rank_r[i] : '0);
      hit_value = hit_value | (match_oh[i] ? entry_val_r[i]  : '0);
    end
  end

  // zero acts as one, anything above the table size saturates
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
  end

  assign hit      = |match_oh;
  assign is_put   = (s1_cmd_r == CMD_PUT);
  assign can_fill = CMP_W'(occ_r) < eff_cap;
  assign out_free = !out_valid_r || out_tready;
  assign proc     = s1_valid_r && (is_put || out_free);
  assign fill     = proc && is_put && !hit && can_fill;
  assign touch    = proc && (hit || is_put);
  assign wr_oh    = hit ? match_oh : (can_fill ? free_oh : victim_oh);
  assign age_limit = hit ? hit_rank : oldest_rank;

  assign in_tready = !s1_valid_r || proc;

  // touched entry goes to rank 0; younger valid entries age by one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      entry_rank_nxt[i] = entry_rank_r[i];
      if (touch) begin
        if (wr_oh[i]) begin
          entry_rank_nxt[i] = '0;
        end else if (entry_valid_r[i] && (fill || entry_rank_r[i] < age_limit)) begin
          entry_rank_nxt[i] = entry_rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r         <= CAP_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      occ_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (proc && !is_put) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (fill) begin
        entry_valid_r <= entry_valid_r | free_oh;
        occ_r         <= occ_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_key_r <= in_tdata[KEY_W-1:0];
      s1_val_r <= in_tdata[KEY_W +: VAL_W];
    end
    if (proc && !is_put) begin
      out_hit_r <= hit;
      out_val_r <= hit ? hit_value : MISS_VALUE;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      entry_rank_r[i] <= entry_rank_nxt[i];
      if (proc && is_put && wr_oh[i]) begin
        entry_key_r[i] <= s1_key_r;
        entry_val_r[i] <= s1_val_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_val_r;

endmodule

>>> verif/lru_cache_table_tb.sv
// Testbench for lru_cache_table: directed and random get/put traffic checked against a predictor.
`timescale 1ns / 1ps

module lru_cache_table_tb;
  import lruc_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 6;
  localparam int POOL_SIZE    = 24;

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] rd_value;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic                 in_tuser;   // [0] cmd
  logic [2*KEY_W-1:0]   in_tdata;   // [31:0] key, [63:32] value
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 out_tuser;  // [0] hit
  logic [VAL_W-1:0]     out_tdata;  // [31:0] read_value
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;

  lru_cache_table #(.ENTRIES(ENTRIES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Predicted cache contents
  logic [KEY_W-1:0] cache_key   [ENTRIES];
  logic [VAL_W-1:0] cache_val   [ENTRIES];
  bit               cache_valid [ENTRIES];
  int unsigned      cache_rank  [ENTRIES];
  int unsigned      cache_occ;
  int unsigned      cache_cap;

  lookup_result_t lookup_results_q[$];
  int unsigned    err_count = 0;

  // Receiver control
  int unsigned rx_hold_req   = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_pick;
  bit          rx_no_stall   = 1'b0;
  bit          tx_no_stall   = 1'b0;

  // Entry e becomes most recent; valid entries younger than lim age by one.
  function automatic void make_recent(int e, int unsigned lim);
    for (int i = 0; i < ENTRIES; i++)
      if (i != e && cache_valid[i] && cache_rank[i] < lim) cache_rank[i]++;
    cache_rank[e] = 0;
  endfunction

  function automatic void cache_access(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int             e;
    int unsigned    cap;
    lookup_result_t r;
    e = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (e < 0 && cache_valid[i] && cache_key[i] == k) e = i;
    if (cmd == CMD_GET) begin
      if (e >= 0) begin
        make_recent(e, cache_rank[e]);
        r.hit      = 1'b1;
        r.rd_value = cache_val[e];
      end else begin
        r.hit      = 1'b0;
        r.rd_value = MISS_VALUE;
      end
      lookup_results_q = {lookup_results_q, r};
      return;
    end
    if (e >= 0) begin
      cache_val[e] = v;
      make_recent(e, cache_rank[e]);
      return;
    end
    cap = (cache_cap == 0) ? 1 : ((cache_cap > ENTRIES) ? ENTRIES : cache_cap);
    if (cache_occ < cap)
      for (int i = 0; i < ENTRIES; i++)
        if (e < 0 && !cache_valid[i]) e = i;
    if (e >= 0) begin
      make_recent(e, 255);
      cache_valid[e] = 1'b1;
      cache_key[e]   = k;
      cache_val[e]   = v;
      cache_occ++;
      return;
    end
    // evict the oldest; first of equal ranks wins
    for (int i = 0; i < ENTRIES; i++)
      if (cache_valid[i] && (e < 0 || cache_rank[i] > cache_rank[e])) e = i;
    if (e < 0) begin
      e              = 0;
      cache_valid[0] = 1'b1;
      cache_rank[0]  = 0;
      cache_occ      = 1;
    end
    cache_key[e] = k;
    cache_val[e] = v;
    make_recent(e, cache_rank[e]);
  endfunction

  function automatic int unsigned tx_gap();
    int unsigned p;
    if (tx_no_stall) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_access(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {v, k};
    do @(posedge clk); while (!in_tready);
    cache_access(cmd, k, v);
  endtask

  task automatic idle_input(int unsigned n);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pauses the sender until every lookup has returned and puts have settled.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cache_cap = c;
  endtask

  // Lookups on an empty cache with the reset capacity
  task automatic test_empty_lookups();
    send_access(CMD_GET, '0, 32'h1234_5678);
    send_access(CMD_GET, '1, '1);
    idle_input(2);
  endtask

  // Hit, update of a present key, and eviction of the oldest entry
  task automatic test_hit_update_evict();
    set_capacity(CAP_W'(2));
    send_access(CMD_PUT, '0, 32'h7FFF_FFFF);
    send_access(CMD_PUT, '1, 32'h8000_0000);
    send_access(CMD_GET, '0, '0);
    send_access(CMD_PUT, '1, '1);
    send_access(CMD_PUT, 32'd5, '0);
    send_access(CMD_GET, '0, '0);
    send_access(CMD_GET, '1, '0);
    send_access(CMD_GET, 32'd5, 32'hA5A5_5A5A);
  endtask

  // Capacity lowered below occupancy: puts replace, nothing is dropped
  task automatic test_capacity_shrink();
    set_capacity(CAP_W'(16));
    send_access(CMD_PUT, 32'd10, 32'd100);
    send_access(CMD_PUT, 32'd11, 32'd101);
    send_access(CMD_PUT, 32'd12, 32'hFFFF_FF00);
    set_capacity(CAP_W'(1));
    send_access(CMD_PUT, 32'd13, 32'd103);
    send_access(CMD_GET, '1, '0);
    send_access(CMD_GET, 32'd13, '0);
    send_access(CMD_PUT, 32'd14, 32'd104);
    send_access(CMD_GET, 32'd12, '0);
    send_access(CMD_GET, 32'd10, '0);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    logic [KEY_W-1:0] keys [6];
    set_capacity(CAP_W'(4));
    for (int i = 0; i < 6; i++) keys[i] = $urandom;
    rx_hold_req = 150;
    for (int i = 0; i < 40; i++)
      send_access((i % 4 == 0) ? CMD_PUT : CMD_GET, keys[$urandom_range(0, 5)], $urandom);
    wait_drain();
  endtask

  // Random gets and puts over a small key pool at several capacities
  task automatic test_random_traffic();
    int unsigned      caps [8] = '{16, 1, 5, 12, 2, 16, 8, 3};
    logic [KEY_W-1:0] pool [POOL_SIZE];
    logic [KEY_W-1:0] k;
    logic             cmd;
    int unsigned      pool_n;
    for (int p = 0; p < 8; p++) begin
      set_capacity(CAP_W'(caps[p]));
      rx_no_stall = (p == 3);
      tx_no_stall = (p == 3);
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
      if (p == 0) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      pool_n = caps[p] + 4;
      for (int n = 0; n < 45; n++) begin
        k   = ($urandom_range(0, 99) < 8) ? KEY_W'($urandom) : pool[$urandom_range(0, pool_n - 1)];
        cmd = 1'($urandom_range(0, 1));
        send_access(cmd, k, $urandom);
        idle_input(tx_gap());
      end
    end
    rx_no_stall = 1'b0;
    tx_no_stall = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_stall_left = rx_hold_req;
      rx_hold_req   = 0;
    end
    if (rx_stall_left != 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!rx_no_stall) begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick >= 94) rx_stall_left = $urandom_range(8, 40);
        else if (rx_pick >= 70) rx_stall_left = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (lookup_results_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result beat: hit=%0b value=%h", out_tuser, out_tdata);
      end else begin
        exp_r = lookup_results_q.pop_front();
        if (out_tuser !== exp_r.hit || out_tdata !== exp_r.rd_value) begin
          err_count++;
          if (err_count <= 10)
            $display("lookup mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                     exp_r.hit, exp_r.rd_value, out_tuser, out_tdata);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= 1'b0;
    in_tdata    <= '0;
    out_tready  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i]   = '0;
      cache_val[i]   = '0;
      cache_rank[i]  = 0;
    end
    cache_occ = 0;
    cache_cap = CAP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_lookups();
    test_hit_update_evict();
    test_capacity_shrink();
    test_backpressure();
    test_random_traffic();
    wait_drain();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
